// ----- sv/dmma_pkg.sv -----
// ----------------------------------------------------------------------------
// dmma_pkg: shared types and constants
// Field widths, item codes, accumulator limits and sequencer states of the
// dense matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
package dmma_pkg;

	localparam int unsigned IDX_W   = 3;   // row / column index width
	localparam int unsigned DIM_W   = 4;   // configured dimension width
	localparam int unsigned AB_W    = 16;  // Q8.8 element of A or B
	localparam int unsigned PROD_W  = 32;  // Q16.16 product
	localparam int unsigned C_W     = 40;  // Q24.16 accumulator
	localparam int unsigned OP_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_W    = 64;  // input tdata width
	localparam int unsigned OUT_W   = 48;  // output tdata width

	localparam logic [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
	localparam logic [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_LOAD_C = 2'd2,
		OP_START  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2,
		REG_UNUSED    = 2'd3
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_M_RD  = 6'b000010,
		ST_M_MUL = 6'b000100,
		ST_M_ACC = 6'b001000,
		ST_E_RD  = 6'b010000,
		ST_E_OUT = 6'b100000
	} state_t;

endpackage

// ----- sv/dmma_mac.sv -----
// ----------------------------------------------------------------------------
// dmma_mac: shared multiply / saturating accumulate unit
// Registers the signed product of two Q8.8 operands, then adds it to a
// Q24.16 accumulator value and clamps the sum to the 40-bit range.
// ----------------------------------------------------------------------------
module dmma_mac (
	input  logic                                 clk,
	input  logic                                 mul_en,
	input  logic signed [dmma_pkg::AB_W-1:0]     a,
	input  logic signed [dmma_pkg::AB_W-1:0]     b,
	input  logic signed [dmma_pkg::C_W-1:0]      acc,
	output logic signed [dmma_pkg::C_W-1:0]      sum
);

	logic signed [dmma_pkg::PROD_W-1:0] prod_s2;
	logic signed [dmma_pkg::C_W:0]      wide_sum;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s2 <= a * b;
		end
	end

	assign wide_sum = {acc[dmma_pkg::C_W-1], acc}
		+ {{(dmma_pkg::C_W+1-dmma_pkg::PROD_W){prod_s2[dmma_pkg::PROD_W-1]}}, prod_s2};

	// clamp when the two top bits disagree
	always_comb begin
		if (wide_sum[dmma_pkg::C_W] != wide_sum[dmma_pkg::C_W-1]) begin
			sum = wide_sum[dmma_pkg::C_W] ? dmma_pkg::C_MIN : dmma_pkg::C_MAX;
		end else begin
			sum = wide_sum[dmma_pkg::C_W-1:0];
		end
	end

endmodule

// ----- sv/dense_matrix_multiply_accumulate_core.sv -----
// ----------------------------------------------------------------------------
// dense_matrix_multiply_accumulate_core: C += A * B on small dense matrices
// Element stores for A, B and C, a small sequencer and one shared
// multiply / saturating accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream items carry one command each, its opcode on s_tuser. Load
//   items write one element of A, B or C at (row, col) and are taken
//   while idle; loads whose index is not below MAX_DIM are dropped. A start
//   item runs C += A * B in i, k, j order over the configured dimensions and
//   then streams out every C element in use, row-major, with m_tlast on the
//   final one.
//   Each multiply-accumulate step goes through the one MAC unit as read
//   stores, multiply, add and write back; each emitted element is read
//   from C and then presented as an item, which holds while m_tready is
//   low. s_tready is low from the start item until the last result item
//   is taken.
//   Configuration writes (dimension registers, 0 acts as 1, values above
//   MAX_DIM act as MAX_DIM) are always accepted and are meant for idle time.
//   Reset sets all dimensions to 8 and clears C through per-entry valid bits;
//   A and B hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_accumulate_core #(
	parameter int MAX_DIM = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tuser: opcode[1:0]
	// s_tdata: row_index[2:0], col_index[5:3], ab_value[21:6],
	//          c_init[61:22], zero[63:62]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [dmma_pkg::IN_W-1:0]            s_tdata,
	input  logic [dmma_pkg::OP_W-1:0]            s_tuser,
	// m_tdata: c_value[39:0], c_row[42:40], c_col[45:43], zero[47:46]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dmma_pkg::OUT_W-1:0]           m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dmma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmma_pkg::DIM_W-1:0]           cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic [dmma_pkg::IDX_W-1:0] idx_t;
	typedef logic [dmma_pkg::DIM_W-1:0] dim_t;

	function automatic logic [AW-1:0] addr_of(input idx_t r, input idx_t c);
		return AW'(32'(r) * MAX_DIM + 32'(c));
	endfunction

	function automatic dim_t dim_eff(input dim_t raw);
		dim_t d;
		if (raw == '0) begin
			d = dim_t'(1);
		end else if (32'(raw) > MAX_DIM) begin
			d = dim_t'(MAX_DIM);
		end else begin
			d = raw;
		end
		return d;
	endfunction

	// input item fields
	dmma_pkg::opcode_t               in_op;
	idx_t                            in_row;
	idx_t                            in_col;
	logic [dmma_pkg::AB_W-1:0]       in_ab;
	logic [dmma_pkg::C_W-1:0]        in_c;

	assign in_op  = dmma_pkg::opcode_t'(s_tuser);
	assign in_row = s_tdata[2:0];
	assign in_col = s_tdata[5:3];
	assign in_ab  = s_tdata[21:6];
	assign in_c   = s_tdata[61:22];

	dmma_pkg::state_t                state_q;
	dim_t                            rows_a_q, inner_dim_q, cols_b_q;
	dim_t                            nr, nk, nc;
	idx_t                            i_q, k_q, j_q;
	logic                            i_end, k_end, j_end;

	logic [dmma_pkg::AB_W-1:0]       a_mem [DEPTH];
	logic [dmma_pkg::AB_W-1:0]       b_mem [DEPTH];
	logic [dmma_pkg::C_W-1:0]        c_mem [DEPTH];
	logic [DEPTH-1:0]                c_vld_q;

	logic signed [dmma_pkg::AB_W-1:0] a_rd_s1, b_rd_s1;
	logic [dmma_pkg::C_W-1:0]        c_rd_q;
	logic                            c_rd_vld_q;
	logic signed [dmma_pkg::C_W-1:0] c_cur;
	logic signed [dmma_pkg::C_W-1:0] mac_sum;

	logic                            in_acc;
	logic                            load_ok;
	logic [AW-1:0]                   ld_addr;
	logic [AW-1:0]                   c_addr;
	logic                            c_we;
	logic [AW-1:0]                   c_waddr;
	logic [dmma_pkg::C_W-1:0]        c_wdata;
	logic                            c_re;
	logic                            out_acc;

	assign nr = dim_eff(rows_a_q);
	assign nk = dim_eff(inner_dim_q);
	assign nc = dim_eff(cols_b_q);

	assign i_end = ({1'b0, i_q} == nr - dim_t'(1));
	assign k_end = ({1'b0, k_q} == nk - dim_t'(1));
	assign j_end = ({1'b0, j_q} == nc - dim_t'(1));

	assign s_tready  = (state_q == dmma_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;

	assign load_ok = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
	assign ld_addr = addr_of(in_row, in_col);
	assign c_addr  = addr_of(i_q, j_q);

	// single write port on C: accumulate results in the accumulate state, loads otherwise
	always_comb begin
		if (state_q == dmma_pkg::ST_M_ACC) begin
			c_we    = 1'b1;
			c_waddr = c_addr;
			c_wdata = mac_sum;
		end else begin
			c_we    = in_acc && load_ok && (in_op == dmma_pkg::OP_LOAD_C);
			c_waddr = ld_addr;
			c_wdata = in_c;
		end
	end

	assign c_re = (state_q == dmma_pkg::ST_M_RD) || (state_q == dmma_pkg::ST_E_RD);

	always_ff @(posedge clk) begin
		if (in_acc && load_ok && in_op == dmma_pkg::OP_LOAD_A) begin
			a_mem[ld_addr] <= in_ab;
		end
		if (in_acc && load_ok && in_op == dmma_pkg::OP_LOAD_B) begin
			b_mem[ld_addr] <= in_ab;
		end
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
		if (state_q == dmma_pkg::ST_M_RD) begin
			a_rd_s1 <= a_mem[addr_of(i_q, k_q)];
			b_rd_s1 <= b_mem[addr_of(k_q, j_q)];
		end
		if (c_re) begin
			c_rd_q <= c_mem[c_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q    <= '0;
			c_rd_vld_q <= 1'b0;
		end else begin
			if (c_we) begin
				c_vld_q[c_waddr] <= 1'b1;
			end
			if (c_re) begin
				c_rd_vld_q <= c_vld_q[c_addr];
			end
		end
	end

	// never-written C entries read as zero
	assign c_cur = c_rd_vld_q ? c_rd_q : '0;

	dmma_mac u_mac (
		.clk    (clk),
		.mul_en (state_q == dmma_pkg::ST_M_MUL),
		.a      (a_rd_s1),
		.b      (b_rd_s1),
		.acc    (c_cur),
		.sum    (mac_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= dim_t'(8);
			inner_dim_q <= dim_t'(8);
			cols_b_q    <= dim_t'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (dmma_pkg::cfg_reg_t'(cfg_index))
				dmma_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data;
				dmma_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				dmma_pkg::REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmma_pkg::ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				dmma_pkg::ST_IDLE: begin
					if (in_acc && in_op == dmma_pkg::OP_START) begin
						i_q     <= '0;
						k_q     <= '0;
						j_q     <= '0;
						state_q <= dmma_pkg::ST_M_RD;
					end
				end
				dmma_pkg::ST_M_RD:  state_q <= dmma_pkg::ST_M_MUL;
				dmma_pkg::ST_M_MUL: state_q <= dmma_pkg::ST_M_ACC;
				dmma_pkg::ST_M_ACC: begin
					// advance j fastest, then k, then i
					state_q <= dmma_pkg::ST_M_RD;
					if (!j_end) begin
						j_q <= j_q + idx_t'(1);
					end else begin
						j_q <= '0;
						if (!k_end) begin
							k_q <= k_q + idx_t'(1);
						end else begin
							k_q <= '0;
							if (!i_end) begin
								i_q <= i_q + idx_t'(1);
							end else begin
								i_q     <= '0;
								state_q <= dmma_pkg::ST_E_RD;
							end
						end
					end
				end
				dmma_pkg::ST_E_RD: state_q <= dmma_pkg::ST_E_OUT;
				dmma_pkg::ST_E_OUT: begin
					if (out_acc) begin
						if (i_end && j_end) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= dmma_pkg::ST_IDLE;
						end else begin
							state_q <= dmma_pkg::ST_E_RD;
							if (j_end) begin
								j_q <= '0;
								i_q <= i_q + idx_t'(1);
							end else begin
								j_q <= j_q + idx_t'(1);
							end
						end
					end
				end
				default: state_q <= dmma_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == dmma_pkg::ST_E_OUT);
	assign m_tdata  = {2'b00, j_q, i_q, c_cur};
	assign m_tlast  = i_end && j_end;

	a_busy_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result item is pending");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_op == dmma_pkg::OP_START |=> state_q == dmma_pkg::ST_M_RD)
		else $error("start item did not launch the multiply loop");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tlast |=> s_tready)
		else $error("block not ready after final result item");

	a_acc_writes_c: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dmma_pkg::ST_M_ACC |-> $past(state_q) == dmma_pkg::ST_M_MUL)
		else $error("accumulate step without a product");

endmodule
